FILE: rtl/core/rgb_box_filter_3x3_unit_defines.svh
// ----------------------------------------------------------------------------
// RGB 3x3 box filter: assertion macros
// Shared property wrappers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef RGB_BOX_FILTER_3X3_UNIT_DEFINES_SVH
`define RGB_BOX_FILTER_3X3_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RBF_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define RBF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RBF_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define RBF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/core/rbf_pkg.sv
// ----------------------------------------------------------------------------
// RGB 3x3 box filter package
// Shared constants, controller states and the lane control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package rbf_pkg;

  localparam int IMAGE_WIDTH_DEF  = 128;
  localparam int IMAGE_HEIGHT_DEF = 128;

  localparam int NUM_LANES  = 3;
  localparam int CH_W       = 8;
  localparam int PIX_W      = NUM_LANES * CH_W;
  localparam int SUM_W      = 12;
  localparam int OUT_W      = 12;
  localparam int DIV_W      = 5;
  localparam int DIV_STEPS  = SUM_W;
  localparam int IN_DATA_W  = ((PIX_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((NUM_LANES * OUT_W + 7) / 8) * 8;

  localparam logic [DIV_W-1:0] DIVISOR_RESET = 5'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WIN,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic update;
    logic row_start;
    logic div_load;
    logic div_step;
  } lane_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/rbf_line_buf.sv
// ----------------------------------------------------------------------------
// RGB 3x3 box filter line buffer
// One-port-read, one-port-write memory holding the two previous rows per
// column, with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_line_buf #(
  parameter int DEPTH  = rbf_pkg::IMAGE_WIDTH_DEF,
  parameter int DATA_W = 2 * rbf_pkg::PIX_W
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DATA_W-1:0]        rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]        wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rbf_lane.sv
// ----------------------------------------------------------------------------
// RGB 3x3 box filter channel lane
// Holds one channel of the two newest window columns, forms the nine-value
// sum and divides it by the divisor one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_lane (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire rbf_pkg::lane_ctrl_t          ctrl,
  input  wire logic [rbf_pkg::CH_W-1:0]     up_val,
  input  wire logic [rbf_pkg::CH_W-1:0]     lo_val,
  input  wire logic [rbf_pkg::CH_W-1:0]     px_val,
  input  wire logic [rbf_pkg::DIV_W-1:0]    divisor,
  output logic      [rbf_pkg::OUT_W-1:0]    quotient
);

  localparam int CW = rbf_pkg::CH_W;
  localparam int SW = rbf_pkg::SUM_W;
  localparam int DW = rbf_pkg::DIV_W;

  logic [CW-1:0] col_a [3];
  logic [CW-1:0] col_b [3];
  logic [SW-1:0] sum_old;
  logic [SW-1:0] sum_new;
  logic [SW-1:0] sum;

  logic [SW-1:0] q;
  logic [DW-1:0] rem;
  logic [DW:0]   rem_shift;
  logic [DW:0]   rem_sub;
  logic          ge;

  always_comb begin
    sum_old = SW'(col_a[0]) + SW'(col_a[1]) + SW'(col_a[2])
            + SW'(col_b[0]) + SW'(col_b[1]) + SW'(col_b[2]);
    sum_new = SW'(up_val) + SW'(lo_val) + SW'(px_val);
    sum     = ctrl.row_start ? sum_old : sum_old + sum_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        col_a[i] <= '0;
        col_b[i] <= '0;
      end
    end else if (ctrl.update) begin
      for (int i = 0; i < 3; i++) begin
        col_a[i] <= ctrl.row_start ? '0 : col_b[i];
      end
      col_b[0] <= up_val;
      col_b[1] <= lo_val;
      col_b[2] <= px_val;
    end
  end

  always_comb begin
    rem_shift = {rem, q[SW-1]};
    ge        = rem_shift >= {1'b0, divisor};
    rem_sub   = rem_shift - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (ctrl.div_load) begin
      q   <= sum;
      rem <= '0;
    end else if (ctrl.div_step) begin
      q   <= {q[SW-2:0], ge};
      rem <= ge ? rem_sub[DW-1:0] : rem_shift[DW-1:0];
    end
  end

  assign quotient = (divisor == '0) ? '1 : rbf_pkg::OUT_W'(q);

endmodule

`default_nettype wire

FILE: rtl/core/rgb_box_filter_3x3_unit.sv
// ----------------------------------------------------------------------------
// RGB 3x3 box filter unit
// Streaming 3x3 box blur over RGB frames in raster order, zero outside the
// frame, one lane per color channel, sums divided by a programmable divisor.
// ----------------------------------------------------------------------------
// An accepted item moves from ST_IDLE to ST_WIN. An item that completes a result then
// runs the 12-step divider in each lane (ST_DIV) and waits in ST_OUT while the previous
// result still waits for m_tready; the result is then registered onto m_tdata.
// s_tready is high only in ST_IDLE, so no new item is taken while one is in progress.
// Reset clears the stream position, window and handshakes; divisor returns to 8.
// Line buffers are not cleared; stale rows are masked by the row position.
`default_nettype none

`include "rgb_box_filter_3x3_unit_defines.svh"

module rgb_box_filter_3x3_unit #(
  parameter int IMAGE_WIDTH  = rbf_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = rbf_pkg::IMAGE_HEIGHT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [rbf_pkg::DIV_W-1:0]        cfg_wdata,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // red_in [7:0], green_in [15:8], blue_in [23:16]
  input  wire logic [rbf_pkg::IN_DATA_W-1:0]    s_tdata,
  // flush
  input  wire logic                             s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // red_out [11:0], green_out [23:12], blue_out [35:24], zeros above
  output logic      [rbf_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                                  m_tlast
);

  localparam int COL_W  = $clog2(IMAGE_WIDTH);
  localparam int ROW_W  = $clog2(IMAGE_HEIGHT + 2);
  localparam int PW     = rbf_pkg::PIX_W;
  localparam int CW     = rbf_pkg::CH_W;
  localparam int OW     = rbf_pkg::OUT_W;
  localparam int NL     = rbf_pkg::NUM_LANES;
  localparam int CNT_W  = $clog2(rbf_pkg::DIV_STEPS);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(IMAGE_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_PAD  = ROW_W'(IMAGE_HEIGHT);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(IMAGE_HEIGHT + 1);
  localparam logic [ROW_W-1:0] ROW_ONE  = ROW_W'(1);
  localparam logic [ROW_W-1:0] ROW_TWO  = ROW_W'(2);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(rbf_pkg::DIV_STEPS - 1);

  rbf_pkg::state_t     state;
  rbf_pkg::state_t     state_next;
  rbf_pkg::lane_ctrl_t lane_ctrl;

  logic [rbf_pkg::DIV_W-1:0] divisor;
  logic [COL_W-1:0]          column_count;
  logic [ROW_W-1:0]          row_count;
  logic [CNT_W-1:0]          div_count;
  logic [PW-1:0]             px;
  logic                      last;

  logic                      in_accept;
  logic                      out_load;
  logic                      emit;
  logic [2*PW-1:0]           rd_data;
  logic [PW-1:0]             up_pix;
  logic [PW-1:0]             lo_pix;
  logic [OW-1:0]             quotient [NL];

  assign in_accept = s_tvalid && s_tready;
  assign s_tready  = (state == rbf_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      divisor <= rbf_pkg::DIVISOR_RESET;
    end else if (cfg_we) begin
      divisor <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      px <= (s_tuser || row_count >= ROW_PAD) ? '0 : s_tdata[PW-1:0];
    end
  end

  rbf_line_buf #(
    .DEPTH  (IMAGE_WIDTH),
    .DATA_W (2 * PW)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (column_count),
    .rd_data (rd_data),
    .wr_en   (state == rbf_pkg::ST_WIN),
    .wr_addr (column_count),
    .wr_data ({rd_data[PW-1:0], px})
  );

  assign up_pix = (row_count >= ROW_TWO) ? rd_data[2*PW-1:PW] : '0;
  assign lo_pix = (row_count >= ROW_ONE) ? rd_data[PW-1:0] : '0;

  always_comb begin
    if (column_count == '0) begin
      emit = (row_count >= ROW_TWO) && (row_count <= ROW_LAST);
    end else begin
      emit = (row_count >= ROW_ONE) && (row_count <= ROW_PAD);
    end
    lane_ctrl.update    = (state == rbf_pkg::ST_WIN);
    lane_ctrl.row_start = (column_count == '0);
    lane_ctrl.div_load  = (state == rbf_pkg::ST_WIN) && emit;
    lane_ctrl.div_step  = (state == rbf_pkg::ST_DIV);
  end

  for (genvar g = 0; g < NL; g++) begin : g_lane
    rbf_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (lane_ctrl),
      .up_val   (up_pix[g*CW +: CW]),
      .lo_val   (lo_pix[g*CW +: CW]),
      .px_val   (px[g*CW +: CW]),
      .divisor  (divisor),
      .quotient (quotient[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (state == rbf_pkg::ST_WIN) begin
      if (row_count >= ROW_LAST) begin
        column_count <= '0;
        row_count    <= '0;
      end else if (column_count == COL_LAST) begin
        column_count <= '0;
        row_count    <= row_count + ROW_ONE;
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == rbf_pkg::ST_WIN) begin
      last <= (column_count == '0) && (row_count == ROW_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_count <= '0;
    end else if (state == rbf_pkg::ST_DIV) begin
      div_count <= div_count + CNT_W'(1);
    end else begin
      div_count <= '0;
    end
  end

  assign out_load = (state == rbf_pkg::ST_OUT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rbf_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_next = rbf_pkg::ST_WIN;
        end
      end
      rbf_pkg::ST_WIN: begin
        state_next = emit ? rbf_pkg::ST_DIV : rbf_pkg::ST_IDLE;
      end
      rbf_pkg::ST_DIV: begin
        if (div_count == CNT_LAST) begin
          state_next = rbf_pkg::ST_OUT;
        end
      end
      rbf_pkg::ST_OUT: begin
        if (out_load) begin
          state_next = rbf_pkg::ST_IDLE;
        end
      end
      default: state_next = rbf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= rbf_pkg::OUT_DATA_W'({quotient[2], quotient[1], quotient[0]});
      m_tlast <= last;
    end
  end

  `RBF_ASSERT_NEXT(a_accept_to_window, clk, rst, in_accept,
    state == rbf_pkg::ST_WIN, "accepted item did not reach the window step")
  `RBF_ASSERT_IMPLIES(a_row_bound, clk, rst, 1'b1,
    row_count <= ROW_LAST, "row position past the padding rows")
  `RBF_ASSERT_IMPLIES(a_wrap_at_col0, clk, rst, row_count == ROW_LAST,
    column_count == '0, "last padding row left column zero")
  `RBF_ASSERT_NEXT(a_out_load, clk, rst, out_load,
    m_tvalid && (state == rbf_pkg::ST_IDLE), "result load did not raise the output")

endmodule

`default_nettype wire

FILE: tb/sv/rgb_box_filter_3x3_unit_tb.sv
// ----------------------------------------------------------------------------
// RGB 3x3 box filter unit testbench
// Streams the first rows of a frame through the filter. Random back-pressure
// is applied on both streams, and the divisor is changed between phases.
// Every output item is compared with a behavioral line-buffer predictor kept
// inside the bench.
// ----------------------------------------------------------------------------
module rgb_box_filter_3x3_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OUT_W      = rbf_pkg::OUT_W;
  localparam int DIV_W      = rbf_pkg::DIV_W;
  localparam int PIX_W      = rbf_pkg::PIX_W;
  localparam int IN_DATA_W  = rbf_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = rbf_pkg::OUT_DATA_W;

  localparam int IMG_W         = rbf_pkg::IMAGE_WIDTH_DEF;
  localparam int IMG_H         = rbf_pkg::IMAGE_HEIGHT_DEF;
  localparam int SETTLE_CYCLES = 32;
  localparam int STALL_LIMIT   = 4000;
  localparam int NUM_PHASES    = 7;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic       flush;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_item_t;

  typedef struct {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
    logic             frame_end;
  } blur_px_t;

  // Start of row 0 of the first frame; its results appear while row 1 streams in.
  localparam pixel_item_t DIRECTED_PIXELS [24] = '{
    '{1'b0, 8'h00, 8'h00, 8'h00}, '{1'b0, 8'hFF, 8'hFF, 8'hFF},
    '{1'b0, 8'hFF, 8'h00, 8'h00}, '{1'b0, 8'h00, 8'hFF, 8'h00},
    '{1'b0, 8'h00, 8'h00, 8'hFF}, '{1'b1, 8'hFF, 8'hFF, 8'hFF},
    '{1'b0, 8'h55, 8'hAA, 8'h55}, '{1'b0, 8'hAA, 8'h55, 8'hAA},
    '{1'b0, 8'h01, 8'h02, 8'h04}, '{1'b0, 8'h08, 8'h10, 8'h20},
    '{1'b0, 8'h40, 8'h80, 8'h01}, '{1'b1, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'hFE, 8'hFD, 8'hFB}, '{1'b0, 8'hF7, 8'hEF, 8'hDF},
    '{1'b0, 8'hBF, 8'h7F, 8'hFE}, '{1'b0, 8'hFF, 8'hFF, 8'hFF},
    '{1'b0, 8'hFF, 8'hFF, 8'hFF}, '{1'b0, 8'hFF, 8'hFF, 8'hFF},
    '{1'b1, 8'h5A, 8'hA5, 8'h3C}, '{1'b0, 8'hFF, 8'hFF, 8'hFF},
    '{1'b0, 8'h00, 8'h00, 8'h00}, '{1'b0, 8'h80, 8'h80, 8'h80},
    '{1'b0, 8'h7F, 8'h7F, 8'h7F}, '{1'b0, 8'hFF, 8'h00, 8'hFF}
  };

  localparam int PHASE_END [NUM_PHASES] =
    '{300, 560, 700, 1000, 1300, 1650, 1950};
  localparam logic [DIV_W-1:0] PHASE_DIV [NUM_PHASES] =
    '{5'd1, 5'd16, 5'd0, 5'd11, 5'd9, 5'd14, 5'd5};
  localparam int SRC_IDLE [NUM_PHASES] = '{16, 16, 16, 67, 67, 0, 0};
  localparam int DST_IDLE [NUM_PHASES] = '{67, 67, 67, 16, 16, 0, 0};

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [DIV_W-1:0]      cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  s_tuser   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  rgb_box_filter_3x3_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [PIX_W-1:0] row_minus2 [IMG_W];
  logic [PIX_W-1:0] row_minus1 [IMG_W];
  logic [PIX_W-1:0] win [9];
  int unsigned      col_pos = 0;
  int unsigned      row_pos = 0;
  logic [DIV_W-1:0] divisor_q = rbf_pkg::DIVISOR_RESET;
  blur_px_t         expected_blur_q [$];

  int unsigned items_sent     = 0;
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles   = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned dst_idle_pct   = 0;

  initial begin
    for (int i = 0; i < IMG_W; i++) begin
      row_minus2[i] = '0;
      row_minus1[i] = '0;
    end
    for (int k = 0; k < 9; k++) win[k] = '0;
  end

  function automatic logic [OUT_W-1:0] lane_quotient(int first_col, int lane);
    int unsigned total;
    total = 0;
    for (int col = first_col; col < 3; col++)
      for (int row = 0; row < 3; row++)
        total += win[col * 3 + row][23 - 8 * lane -: 8];
    if (divisor_q == '0) return '1;
    return OUT_W'(total / divisor_q);
  endfunction

  function automatic void push_blur(int first_col, logic last);
    blur_px_t px;
    px.red       = lane_quotient(first_col, 0);
    px.green     = lane_quotient(first_col, 1);
    px.blue      = lane_quotient(first_col, 2);
    px.frame_end = last;
    expected_blur_q.push_back(px);
  endfunction

  function automatic void predict_blur(pixel_item_t item);
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] lo;
    int unsigned      c;
    c  = col_pos;
    px = (item.flush || row_pos >= IMG_H) ? '0 : {item.red, item.green, item.blue};
    up = (row_pos >= 2) ? row_minus2[c] : '0;
    lo = (row_pos >= 1) ? row_minus1[c] : '0;
    row_minus2[c] = row_minus1[c];
    row_minus1[c] = px;
    if (c == 0) begin
      if (row_pos >= 2 && row_pos <= IMG_H + 1) push_blur(1, row_pos == IMG_H + 1);
      for (int k = 0; k < 6; k++) win[k] = '0;
    end else begin
      for (int k = 0; k < 6; k++) win[k] = win[k + 3];
    end
    win[6] = up;
    win[7] = lo;
    win[8] = px;
    if (c != 0 && row_pos >= 1 && row_pos <= IMG_H) push_blur(0, 1'b0);
    if (row_pos >= IMG_H + 1) begin
      col_pos = 0;
      row_pos = 0;
    end else if (c + 1 >= IMG_W) begin
      col_pos = 0;
      row_pos = row_pos + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function automatic pixel_item_t pick_random_pixel();
    pixel_item_t item;
    item = pixel_item_t'($urandom);
    if (row_pos >= IMG_H) begin
      item.flush = ($urandom_range(99) < 85);
    end else begin
      item.flush = ($urandom_range(99) < 2);
      if (row_pos % 16 >= 4 && row_pos % 16 <= 6 && col_pos >= 32 && col_pos < 48)
        {item.red, item.green, item.blue} = '1;
      else if (row_pos % 16 >= 4 && row_pos % 16 <= 6 && col_pos >= 64 && col_pos < 80)
        {item.red, item.green, item.blue} = '0;
    end
    return item;
  endfunction

  task automatic send_pixel(pixel_item_t item);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {item.blue, item.green, item.red};
    s_tuser  <= item.flush;
    do @(posedge clk); while (!s_tready);
    predict_blur(item);
    items_sent++;
  endtask

  task automatic settle_block();
    s_tvalid <= 1'b0;
    while (expected_blur_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_divisor(logic [DIV_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    divisor_q = value;
  endtask

  function automatic void flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    blur_px_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_blur_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected item: r=%0d g=%0d b=%0d last=%0b",
                                m_tdata[11:0], m_tdata[23:12], m_tdata[35:24], m_tlast));
      end else begin
        want = expected_blur_q.pop_front();
        if (m_tdata[11:0] !== want.red || m_tdata[23:12] !== want.green ||
            m_tdata[35:24] !== want.blue || m_tlast !== want.frame_end ||
            m_tdata[OUT_DATA_W-1:36] !== '0)
          flag_mismatch($sformatf(
            "mismatch: exp r=%0d g=%0d b=%0d last=%0b, got r=%0d g=%0d b=%0d last=%0b pad=%h",
            want.red, want.green, want.blue, want.frame_end, m_tdata[11:0],
            m_tdata[23:12], m_tdata[35:24], m_tlast, m_tdata[OUT_DATA_W-1:36]));
      end
    end
    m_tready <= !rst && ($urandom_range(99) >= dst_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct = SRC_IDLE[0];
    dst_idle_pct = DST_IDLE[0];
    foreach (DIRECTED_PIXELS[i]) send_pixel(DIRECTED_PIXELS[i]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle_block();
      write_divisor(PHASE_DIV[p]);
      src_idle_pct = SRC_IDLE[p];
      dst_idle_pct = DST_IDLE[p];
      while (items_sent < PHASE_END[p]) send_pixel(pick_random_pixel());
    end

    settle_block();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/rbf_pkg.sv
rtl/core/rbf_line_buf.sv
rtl/core/rbf_lane.sv
rtl/core/rgb_box_filter_3x3_unit.sv
tb/sv/rgb_box_filter_3x3_unit_tb.sv
